FILE: design/slru_pkg.sv
// slru_pkg: request/response payload types, access kind codes and
// controller types for the set-associative lru lookup block
// no dependencies
package slru_pkg;

  localparam int unsigned SET_IN_W  = 6;
  localparam int unsigned TAG_IN_W  = 20;
  localparam int unsigned WAY_OUT_W = 2;
  localparam int unsigned KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_HIT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COLD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONFLICT = 2'd2;

  typedef struct packed {
    logic [SET_IN_W-1:0] set_index;
    logic [TAG_IN_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [WAY_OUT_W-1:0] way;
    logic [KIND_W-1:0]    access_kind;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

FILE: design/set_associative_lru_lookup.sv
// set_associative_lru_lookup: a request and its set row of the line memory are
// read on accept; the row is written and the result registered on commit, which
// waits while a held result is stalled; no new request is taken before commit
// reset clears the controller, the result valid flag and the per-set touched
// flags at once; untouched sets read as all invalid with rank equal to way
// depends on slru_pkg, slru_ctrl, slru_dpath
module set_associative_lru_lookup #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 4,
  parameter int unsigned TAG_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slru_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slru_pkg::rsp_t out_rsp_o
);

  slru_pkg::ctrl_cmd_t cmd;

  slru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  slru_dpath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

FILE: design/slru_ctrl.sv
// slru_ctrl: controller state machine, request/response handshakes
// depends on slru_pkg
module slru_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output slru_pkg::ctrl_cmd_t   cmd_o
);

  slru_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slru_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      slru_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = slru_pkg::ST_LOOKUP;
        end
      end
      slru_pkg::ST_LOOKUP: begin
        // result register must be free or draining
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = slru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slru_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/slru_dpath.sv
// slru_dpath: per-set line memory, lookup, victim choice, rank update
// and result register; depends on slru_pkg
module slru_dpath #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 4,
  parameter int unsigned TAG_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slru_pkg::ctrl_cmd_t cmd_i,
  input  slru_pkg::req_t      req_i,
  output slru_pkg::rsp_t      rsp_o
);

  localparam int unsigned SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam logic [WAY_BITS-1:0] MAX_RANK = WAY_BITS'(NUM_WAYS - 1);

  typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_row_t;
  typedef logic [NUM_WAYS-1:0][WAY_BITS-1:0] rank_row_t;
  typedef logic [NUM_WAYS-1:0]               valid_row_t;

  tag_row_t   tag_mem   [NUM_SETS];
  rank_row_t  rank_mem  [NUM_SETS];
  valid_row_t valid_mem [NUM_SETS];

  logic [NUM_SETS-1:0] touched_q;

  logic [SET_BITS-1:0] set_idx;
  logic [SET_BITS-1:0] set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                touched_rd_q;
  tag_row_t            tag_rd_q;
  rank_row_t           rank_rd_q;
  valid_row_t          valid_rd_q;

  tag_row_t            tag_wr;
  rank_row_t           rank_wr;
  valid_row_t          valid_wr;
  slru_pkg::rsp_t      rsp_d;
  slru_pkg::rsp_t      rsp_q;

  // set index wrap by shift-and-subtract over the narrow input
  always_comb begin
    logic [slru_pkg::SET_IN_W-1:0] red;
    red = req_i.set_index;
    for (int k = slru_pkg::SET_IN_W - 1; k >= 0; k--) begin
      if (32'(red) >= (32'(NUM_SETS) << k)) begin
        red = slru_pkg::SET_IN_W'(32'(red) - (32'(NUM_SETS) << k));
      end
    end
    set_idx = SET_BITS'(red);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q      <= set_idx;
      tag_q      <= TAG_BITS'(req_i.tag);
      tag_rd_q   <= tag_mem[set_idx];
      rank_rd_q  <= rank_mem[set_idx];
      valid_rd_q <= valid_mem[set_idx];
    end
    if (cmd_i.commit) begin
      tag_mem[set_q]   <= tag_wr;
      rank_mem[set_q]  <= rank_wr;
      valid_mem[set_q] <= valid_wr;
      rsp_q            <= rsp_d;
    end
  end

  // untouched sets read as reset: all invalid, rank equals way
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q    <= '0;
      touched_rd_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        touched_rd_q <= touched_q[set_idx];
      end
      if (cmd_i.commit) begin
        touched_q[set_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    valid_row_t          valid_eff;
    rank_row_t           rank_eff;
    logic                hit_any;
    logic                cold_any;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] cold_way;
    logic [WAY_BITS-1:0] lru_way;
    logic [WAY_BITS-1:0] pick;
    logic [WAY_BITS-1:0] old_rank;

    hit_any  = 1'b0;
    cold_any = 1'b0;
    hit_way  = '0;
    cold_way = '0;
    lru_way  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      valid_eff[w] = touched_rd_q ? valid_rd_q[w] : 1'b0;
      rank_eff[w]  = touched_rd_q ? rank_rd_q[w] : WAY_BITS'(w);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_eff[w] && (tag_rd_q[w] == tag_q)) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!valid_eff[w]) begin
        cold_any = 1'b1;
        cold_way = WAY_BITS'(w);
      end
      if (rank_eff[w] == MAX_RANK) begin
        lru_way = WAY_BITS'(w);
      end
    end

    tag_wr   = tag_rd_q;
    valid_wr = valid_eff;
    priority if (hit_any) begin
      pick              = hit_way;
      rsp_d.access_kind = slru_pkg::KIND_HIT;
    end else if (cold_any) begin
      pick              = cold_way;
      rsp_d.access_kind = slru_pkg::KIND_COLD;
    end else begin
      pick              = lru_way;
      rsp_d.access_kind = slru_pkg::KIND_CONFLICT;
    end
    if (!hit_any) begin
      tag_wr[pick]   = tag_q;
      valid_wr[pick] = 1'b1;
    end
    rsp_d.way = slru_pkg::WAY_OUT_W'(pick);

    // move picked line to most recent
    old_rank = rank_eff[pick];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rank_eff[w] < old_rank) begin
        rank_wr[w] = WAY_BITS'(rank_eff[w] + 1'b1);
      end else begin
        rank_wr[w] = rank_eff[w];
      end
    end
    rank_wr[pick] = '0;
  end

  assign rsp_o = rsp_q;

endmodule

FILE: bench/tb_set_associative_lru_lookup.sv
// tb_set_associative_lru_lookup: self-checking bench for the set-associative lru lookup,
// directed fill/hit/eviction requests, then random hot-set and wide-set traffic
// depends on slru_pkg and set_associative_lru_lookup
module tb_set_associative_lru_lookup;

  localparam int unsigned NUM_SETS       = 64;
  localparam int unsigned NUM_WAYS       = 4;
  localparam int unsigned TAG_BITS       = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_e;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  slru_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_stall_i;
  slru_pkg::rsp_t out_rsp_o;

  logic                line_valid [NUM_SETS][NUM_WAYS];
  logic [TAG_BITS-1:0] line_tag   [NUM_SETS][NUM_WAYS];
  logic [1:0]          line_rank  [NUM_SETS][NUM_WAYS];

  slru_pkg::rsp_t expected_rsp_q [$];
  int unsigned    mismatch_count;
  int unsigned    burst_left;
  bit             gaps_on;
  int unsigned    idle_cycles;
  rx_mode_e       rx_mode;
  int unsigned    rx_phase_left;
  logic [7:0]     rx_pattern;

  set_associative_lru_lookup #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .TAG_BITS(TAG_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic slru_pkg::rsp_t predict_access(input slru_pkg::req_t r);
    int unsigned    s;
    int             pick;
    int unsigned    best;
    logic [1:0]     old_rank;
    logic [1:0]     kind;
    slru_pkg::rsp_t rsp;
    s    = 32'(r.set_index);
    pick = -1;
    best = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (pick < 0 && line_valid[s][w] && line_tag[s][w] == r.tag) pick = w;
    end
    if (pick >= 0) begin
      kind = slru_pkg::KIND_HIT;
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!line_valid[s][w] && (pick < 0 || 32'(line_rank[s][w]) < best)) begin
          pick = w;
          best = 32'(line_rank[s][w]);
        end
      end
      if (pick >= 0) begin
        kind = slru_pkg::KIND_COLD;
      end else begin
        pick = 0;
        best = 32'(line_rank[s][0]);
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (32'(line_rank[s][w]) > best) begin
            pick = w;
            best = 32'(line_rank[s][w]);
          end
        end
        kind = slru_pkg::KIND_CONFLICT;
      end
      line_valid[s][pick] = 1'b1;
      line_tag[s][pick]   = r.tag;
    end
    // move the chosen line to most recent
    old_rank = line_rank[s][pick];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (line_rank[s][w] < old_rank) line_rank[s][w] = line_rank[s][w] + 2'd1;
    end
    line_rank[s][pick] = 2'd0;
    rsp.way         = pick[1:0];
    rsp.access_kind = kind;
    return rsp;
  endfunction

  task automatic send_request(input logic [5:0] set_index, input logic [19:0] tag);
    int unsigned    gap;
    slru_pkg::req_t r;
    r.set_index = set_index;
    r.tag       = tag;
    gap         = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rsp_q.push_back(predict_access(r));
  endtask

  task automatic test_cold_fill();
    send_request(6'd0, 20'h00000);
    send_request(6'd0, 20'hFFFFF);
    send_request(6'd0, 20'h55555);
    send_request(6'd0, 20'hAAAAA);
    send_request(6'd63, 20'hFFFFF);
  endtask

  task automatic test_hit_promote();
    send_request(6'd0, 20'hAAAAA);
    send_request(6'd0, 20'h00000);
    send_request(6'd0, 20'h55555);
    send_request(6'd0, 20'h00000);
    send_request(6'd63, 20'hFFFFF);
  endtask

  task automatic test_conflict_evict();
    send_request(6'd0, 20'h12345);
    send_request(6'd0, 20'hFFFFF);
    send_request(6'd0, 20'h12345);
    send_request(6'd0, 20'hAAAAA);
    send_request(6'd63, 20'h00000);
    send_request(6'd63, 20'h00001);
    send_request(6'd63, 20'h80000);
    send_request(6'd63, 20'h7FFFF);
    send_request(6'd63, 20'hFFFFF);
    send_request(6'd63, 20'h00000);
  endtask

  task automatic test_hot_sets(input int unsigned count);
    logic [5:0]  hot_set  [4];
    logic [19:0] tag_pool [6];
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        foreach (hot_set[k]) hot_set[k] = 6'($urandom_range(0, NUM_SETS - 1));
        foreach (tag_pool[k]) tag_pool[k] = 20'($urandom());
      end
      gaps_on = (i % 200) >= 60;
      if ($urandom_range(0, 9) == 0) begin
        send_request(6'($urandom()), 20'($urandom()));
      end else begin
        send_request(hot_set[$urandom_range(0, 3)], tag_pool[$urandom_range(0, 5)]);
      end
    end
  endtask

  task automatic test_wide_sets(input int unsigned count);
    logic [19:0] tag_pool [8];
    foreach (tag_pool[k]) tag_pool[k] = 20'($urandom());
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on = (i % 150) < 100;
      if ($urandom_range(0, 9) < 3) begin
        send_request(6'($urandom()), 20'($urandom()));
      end else begin
        send_request(6'($urandom()), tag_pool[$urandom_range(0, 7)]);
      end
    end
  endtask

  task automatic test_drain();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // response checker
  always @(posedge clk_i) begin
    slru_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response way=%0d kind=%0d", $time,
                 out_rsp_o.way, out_rsp_o.access_kind);
        mismatch_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp_o.way !== want.way) begin
          $display("%0t: way expected %0d actual %0d", $time, want.way, out_rsp_o.way);
          mismatch_count++;
        end
        if (out_rsp_o.access_kind !== want.access_kind) begin
          $display("%0t: access_kind expected %0d actual %0d", $time,
                   want.access_kind, out_rsp_o.access_kind);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_e'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(8, 64);
      rx_pattern    = 8'($urandom());
    end
    rx_phase_left--;
    case (rx_mode)
      RX_FLOW:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        out_stall_i <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("set_associative_lru_lookup: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_stall_i    = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    idle_cycles    = 0;
    rx_mode        = RX_FLOW;
    rx_phase_left  = 0;
    rx_pattern     = '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w]   = '0;
        line_rank[s][w]  = w[1:0];
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cold_fill();
    test_hit_promote();
    test_conflict_evict();
    test_hot_sets(500);
    test_wide_sets(400);
    test_drain();

    if (mismatch_count == 0) begin
      $display("set_associative_lru_lookup: match");
    end else begin
      $display("set_associative_lru_lookup: mismatch");
    end
    $finish;
  end

endmodule
